// ===== src/c_subset_token_scanner_macros.svh =====
// Assertion macros used by the scanner's sequencer.
`ifndef C_SUBSET_TOKEN_SCANNER_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define CSTS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CSTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/csts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_pkg
// Character classes, token kind codes and the operator and keyword tables
// of the token scanner.
// ----------------------------------------------------------------------------
package csts_pkg;

	localparam int MaxTokenLenDef = 32;
	localparam int KwBytes = 8;
	localparam int NumWords = 27;
	localparam int NumSingleOps = 22;

	localparam logic [5:0] KIND_UNKNOWN = 6'd0;
	localparam logic [5:0] KIND_END     = 6'd1;
	localparam logic [5:0] KIND_IDENT   = 6'd2;
	localparam logic [5:0] KIND_NUMBER  = 6'd3;
	localparam logic [5:0] KIND_CHAR    = 6'd4;
	localparam logic [5:0] KIND_STRING  = 6'd5;
	localparam logic [5:0] KIND_OP0     = 6'd6;
	localparam logic [5:0] KIND_WORD0   = 6'd28;

	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_HASH   = 8'd35;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_SLASH  = 8'd47;

	localparam logic [8*NumSingleOps-1:0] SINGLE_OPS = "+-*/%=<>&|^~![](){};,:";

	localparam logic [63:0] WORD_TXT [NumWords] = '{
		64'("=="), 64'("<="), 64'(">="), 64'("<<"), 64'(">>"), 64'("&&"),
		64'("||"), 64'("!="), 64'("->"), 64'("if"), 64'("void"), 64'("int"),
		64'("char"), 64'("double"), 64'("while"), 64'("else"), 64'("return"),
		64'("struct"), 64'("static"), 64'("#include"), 64'("fopen"),
		64'("fclose"), 64'("fgetc"), 64'("fputc"), 64'("malloc"),
		64'("sizeof"), 64'("printf")
	};
	localparam int WORD_LEN [NumWords] = '{
		2, 2, 2, 2, 2, 2, 2, 2, 2, 2, 4, 3, 4, 6, 5, 4, 6, 6, 6, 8, 5, 6, 5, 5,
		6, 6, 6
	};

	typedef logic [KwBytes-1:0][7:0] kw_buf_t;

	typedef struct packed {
		logic done;
		logic str;
		logic chr;
	} ends_t;

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'd32 || c == 8'd10 || c == 8'd13 || c == 8'd9;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) || c == 8'd95;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return !is_ws(c) && !is_letter(c) && !is_digit(c);
	endfunction

	function automatic logic is_term(logic [7:0] c);
		return c == 8'd40 || c == 8'd41 || c == 8'd91 || c == 8'd93 || c == 8'd123 ||
			c == 8'd125 || c == 8'd59 || c == 8'd44 || c == CH_SQUOTE || c == CH_DQUOTE;
	endfunction

	// Pairwise end-of-token rule; also advances the string and char flags.
	function automatic ends_t ends_after(logic [7:0] c, logic [7:0] nx, logic str,
			logic chr);
		ends_t r;
		r.str = str;
		r.chr = chr;
		r.done = 1'b1;
		if (c == CH_DQUOTE && !chr && !str) begin
			r.str = 1'b1;
			r.done = 1'b0;
		end else if (nx == CH_DQUOTE && str) begin
			r.done = 1'b0;
		end else if (c == CH_DQUOTE && str) begin
			r.str = 1'b0;
		end else if (str) begin
			r.done = 1'b0;
		end else if (c == CH_SQUOTE && !chr) begin
			r.chr = 1'b1;
			r.done = 1'b0;
		end else if (nx == CH_SQUOTE && chr) begin
			r.done = 1'b0;
		end else if (c == CH_SQUOTE && chr) begin
			r.chr = 1'b0;
		end else if (chr) begin
			r.done = 1'b0;
		end else if (is_ws(nx) || is_term(c) || is_term(nx)) begin
			r.done = 1'b1;
		end else if (c == CH_HASH) begin
			r.done = 1'b0;
		end else if ((is_letter(c) && is_letter(nx)) || (is_digit(c) && is_digit(nx)) ||
				(is_letter(c) && is_digit(nx)) || (is_op(c) && is_op(nx))) begin
			r.done = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [5:0] classify(kw_buf_t sh, logic [5:0] len, logic cut);
		logic [5:0] k;
		logic hit;
		logic [63:0] word;
		k = KIND_UNKNOWN;
		if (is_letter(sh[0])) k = KIND_IDENT;
		else if (is_digit(sh[0])) k = KIND_NUMBER;
		if (!cut) begin
			for (int w = 0; w < NumWords; w++) begin
				word = WORD_TXT[w] << (8 * (KwBytes - WORD_LEN[w]));
				hit = (len == 6'(WORD_LEN[w]));
				for (int i = 0; i < KwBytes; i++) begin
					if (i < WORD_LEN[w] && sh[i] != word[63-8*i -: 8]) hit = 1'b0;
				end
				if (hit) k = 6'(KIND_WORD0 + 6'(w));
			end
			if (len == 6'd1) begin
				for (int i = 0; i < NumSingleOps; i++) begin
					if (sh[0] == SINGLE_OPS[8*(NumSingleOps-1-i) +: 8])
						k = 6'(KIND_OP0 + 6'(i));
				end
			end
		end
		if (sh[0] == CH_SQUOTE) k = KIND_CHAR;
		if (sh[0] == CH_DQUOTE) k = KIND_STRING;
		return k;
	endfunction

	typedef struct packed {
		logic step;
		logic classify;
		logic load_tok;
		logic load_end;
		logic idx_inc;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic out_last;
	} status_t;

endpackage

// ===== src/csts_ctl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_ctl
// Sequencer: takes input bytes, walks each finished token's result run and
// sends the end token.
// ----------------------------------------------------------------------------
`include "c_subset_token_scanner_macros.svh"

module csts_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              end_of_input,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  csts_pkg::status_t st,
	output csts_pkg::cmd_t    cmd
);
	import csts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CLASS, S_READ, S_LOAD, S_SEND, S_END, S_ESEND, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   eoi_pend_q;
	logic   take;

	assign in_stall  = !(state_q == S_IDLE || state_q == S_DONE);
	assign out_valid = out_valid_q;
	assign take      = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.step     = take && state_q == S_IDLE;
		cmd.classify = state_q == S_CLASS;
		cmd.load_tok = state_q == S_LOAD;
		cmd.load_end = state_q == S_END;
		cmd.idx_inc  = state_q == S_SEND && !out_stall && !st.out_last;
		cmd.clear    = state_q == S_SEND && !out_stall && st.out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			eoi_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						eoi_pend_q <= end_of_input;
						if (st.emit) state_q <= S_CLASS;
						else if (end_of_input) state_q <= S_END;
					end
				end
				S_CLASS: state_q <= S_READ;
				S_READ:  state_q <= S_LOAD;
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (!st.out_last) state_q <= S_READ;
						else if (eoi_pend_q) state_q <= S_END;
						else state_q <= S_IDLE;
					end
				end
				S_END: begin
					out_valid_q <= 1'b1;
					state_q <= S_ESEND;
				end
				S_ESEND: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_DONE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CSTS_ASSERT_NOW(a_step_quiet, cmd.step, !out_valid_q, "byte taken while result pending")
	`CSTS_ASSERT_NEXT(a_done_sticks, state_q == S_DONE, state_q == S_DONE, "left done state")
	`CSTS_ASSERT_NOW(a_send_valid, state_q == S_SEND || state_q == S_ESEND, out_valid_q,
		"send state without valid")

endmodule

// ===== src/csts_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_dp
// Datapath: lookahead, flags, token buffer, counters, classifier and the
// output register.
// ----------------------------------------------------------------------------
module csts_dp #(
	parameter int MAX_TOKEN_LEN = csts_pkg::MaxTokenLenDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              end_of_input,
	input  csts_pkg::cmd_t    cmd,
	output csts_pkg::status_t st,
	output logic [5:0]        token_kind,
	output logic [31:0]       int_value,
	output logic [7:0]        text_byte,
	output logic              text_valid,
	output logic [15:0]       start_line,
	output logic [15:0]       start_column,
	output logic              text_overflow,
	output logic              last_of_token
);
	import csts_pkg::*;

	localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
	localparam int IW = $clog2(MAX_TOKEN_LEN);

	logic [7:0]  la_q;
	logic        la_v_q, str_q, chr_q, cmt_q, cut_q;
	logic [LW-1:0] len_q;
	logic [31:0] acc_q;
	logic [15:0] line_q, col_q, sline_q, scol_q;

	logic [7:0]  mem [MAX_TOKEN_LEN];
	logic [7:0]  rd_q;
	kw_buf_t     sh_q;
	logic [7:0]  last_q;

	logic [5:0]  kind_q;
	logic [LW-1:0] idx_q, to_q;
	logic        empty_q;

	logic [7:0]  c;
	logic        do_app, tok_br, start, room, emit, cmt_n, str_n, chr_n, cut_b;
	logic [31:0] acc_b, acc_n;
	ends_t       er;
	logic [5:0]  kind_c;
	logic [LW-1:0] from_c, to_c;

	always_comb begin
		c = la_q;
		tok_br = 1'b0;
		do_app = 1'b0;
		cmt_n = cmt_q;
		str_n = str_q;
		chr_n = chr_q;
		er = ends_after(c, in_byte, str_q, chr_q);
		if (end_of_input) begin
			do_app = la_v_q && !cmt_q && (len_q != '0 || !is_ws(c));
			cmt_n = 1'b0;
			str_n = 1'b0;
			chr_n = 1'b0;
		end else if (la_v_q) begin
			if (cmt_q) begin
				if (c == CH_LF) cmt_n = 1'b0;
			end else if (len_q == '0 && is_ws(c)) begin
				cmt_n = cmt_q;
			end else if (len_q == '0 && c == CH_SLASH && in_byte == CH_SLASH) begin
				cmt_n = 1'b1;
			end else begin
				do_app = 1'b1;
				tok_br = 1'b1;
				str_n = er.str;
				chr_n = er.chr;
			end
		end
		start = do_app && len_q == '0;
		room  = len_q < LW'(MAX_TOKEN_LEN);
		acc_b = start ? 32'd0 : acc_q;
		cut_b = start ? 1'b0 : cut_q;
		acc_n = is_digit(c) ? 32'(acc_b * 32'd10) + {24'd0, 8'(c - CH_ZERO)} : acc_b;
		emit  = end_of_input ? (len_q != '0 || do_app) : (tok_br && er.done);
	end

	assign st.emit = emit;
	assign st.out_last = last_of_token;

	// Control state of the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q <= '0;
			la_v_q <= 1'b0;
			str_q <= 1'b0;
			chr_q <= 1'b0;
			cmt_q <= 1'b0;
			cut_q <= 1'b0;
			len_q <= '0;
			acc_q <= '0;
			line_q <= 16'd1;
			col_q <= 16'd1;
			sline_q <= 16'd1;
			scol_q <= '0;
		end else if (cmd.clear) begin
			len_q <= '0;
			cut_q <= 1'b0;
		end else if (cmd.step) begin
			cmt_q <= cmt_n;
			str_q <= str_n;
			chr_q <= chr_n;
			if (do_app) begin
				acc_q <= acc_n;
				if (room) begin
					len_q <= len_q + 1'b1;
					cut_q <= cut_b;
				end else begin
					cut_q <= 1'b1;
				end
				if (start) begin
					sline_q <= line_q;
					scol_q <= col_q - 16'd1;
				end
			end
			if (end_of_input) begin
				la_v_q <= 1'b0;
			end else begin
				la_q <= in_byte;
				la_v_q <= 1'b1;
				if (in_byte == CH_LF) begin
					line_q <= line_q + 16'd1;
					col_q <= 16'd1;
				end else begin
					col_q <= col_q + 16'd1;
				end
			end
		end
	end

	// Token text, keyword window and run bookkeeping.
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[IW-1:0]];
		if (cmd.step && do_app && room) begin
			mem[len_q[IW-1:0]] <= c;
			last_q <= c;
			if (len_q < LW'(KwBytes)) sh_q[len_q[$clog2(KwBytes)-1:0]] <= c;
		end
		if (cmd.classify) begin
			kind_q <= kind_c;
			idx_q <= from_c;
			to_q <= to_c;
			empty_q <= !(to_c > from_c);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		kind_c = classify(sh_q, 6'(len_q), cut_q);
		from_c = '0;
		to_c = '0;
		if (kind_c == KIND_IDENT) begin
			to_c = len_q;
		end else if (kind_c == KIND_CHAR || kind_c == KIND_STRING) begin
			from_c = LW'(1);
			to_c = len_q;
			if (!cut_q && len_q >= LW'(2) && last_q == sh_q[0]) to_c = len_q - 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			token_kind <= kind_q;
			int_value <= (kind_q == KIND_NUMBER) ? acc_q : 32'd0;
			text_byte <= empty_q ? 8'd0 : rd_q;
			text_valid <= !empty_q;
			start_line <= sline_q;
			start_column <= scol_q;
			text_overflow <= cut_q;
			last_of_token <= empty_q || (idx_q + 1'b1 == to_q);
		end else if (cmd.load_end) begin
			token_kind <= KIND_END;
			int_value <= '0;
			text_byte <= '0;
			text_valid <= 1'b0;
			start_line <= line_q;
			start_column <= col_q;
			text_overflow <= 1'b0;
			last_of_token <= 1'b1;
		end
	end

endmodule

// ===== src/c_subset_token_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Streaming scanner for a small C subset, one source byte per transfer.
// ----------------------------------------------------------------------------
// Each input byte is held as lookahead and judged against the byte after it,
// so the first byte only fills the lookahead. Whitespace and // comments
// between tokens are dropped; a finished token is classed and sent out as a
// run of result transfers (one per identifier byte or literal byte between
// the quotes, else a single transfer), with last_of_token on the final one.
// An input transfer that finishes no token leaves the input side ready for
// the next byte. A finished token is first classed, then each result takes
// a token buffer read, an output load and the output transfer itself;
// the input side stalls while a run is out, since the token buffer has one
// read port. end_of_input flushes the pending byte and token, sends an end
// token, and then every later input transfer is accepted and dropped until
// reset. Tokens longer than MAX_TOKEN_LEN are cut and flagged.
// ----------------------------------------------------------------------------
module c_subset_token_scanner #(
	parameter int MAX_TOKEN_LEN = csts_pkg::MaxTokenLenDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [31:0] int_value,
	output logic [7:0]  text_byte,
	output logic        text_valid,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic        text_overflow,
	output logic        last_of_token
);
	import csts_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer: owns the handshakes and the order of each run.
	csts_ctl u_ctl (
		.clk,
		.arst_n,
		.in_valid,
		.end_of_input,
		.in_stall,
		.out_valid,
		.out_stall,
		.st,
		.cmd
	);

	// Datapath: scan state, token buffer, classifier and output register.
	csts_dp #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_dp (
		.clk,
		.arst_n,
		.in_byte,
		.end_of_input,
		.cmd,
		.st,
		.token_kind,
		.int_value,
		.text_byte,
		.text_valid,
		.start_line,
		.start_column,
		.text_overflow,
		.last_of_token
	);

endmodule

// ===== verif/c_subset_token_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_token_scanner_tb
// Self-checking bench for the token scanner.
// ----------------------------------------------------------------------------
// Feeds C-like source text byte by byte (directed text, then random
// fragments with some noise) and predicts every token transfer with its own
// scanner model. Results are checked field by field in order. Both sides
// idle and stall at random in several phases, and once the receiver holds
// off for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_tb;
	import csts_pkg::*;

	typedef struct {
		logic [5:0]  kind;
		logic [31:0] value;
		logic [7:0]  tbyte;
		logic        tvalid;
		logic [15:0] line;
		logic [15:0] col;
		logic        ovf;
		logic        last;
	} token_xfer_t;

	// Scanner model plus the store of expected token transfers.
	class token_board;
		token_xfer_t pending[$];
		int errors;
		logic [7:0]  la_char;
		logic        la_ok, in_str, in_chr, in_cmt, cut, done;
		logic [7:0]  buf_b[32];
		int          tlen;
		logic [31:0] acc;
		logic [15:0] line_no, col_no, tok_line, tok_col;
		string       ops;
		string       words[27];

		function new();
			ops = "+-*/%=<>&|^~![](){};,:";
			words = '{"==", "<=", ">=", "<<", ">>", "&&", "||", "!=", "->", "if", "void",
				"int", "char", "double", "while", "else", "return", "struct", "static",
				"#include", "fopen", "fclose", "fgetc", "fputc", "malloc", "sizeof",
				"printf"};
			la_char = 0; la_ok = 0; in_str = 0; in_chr = 0; in_cmt = 0; cut = 0;
			done = 0; tlen = 0; acc = 0; line_no = 1; col_no = 1; tok_line = 1;
			tok_col = 0; errors = 0;
		endfunction

		function bit ws(logic [7:0] c);
			return c == 32 || c == 10 || c == 13 || c == 9;
		endfunction
		function bit letter(logic [7:0] c);
			return (c >= 97 && c <= 122) || (c >= 65 && c <= 90) || c == 95;
		endfunction
		function bit digit(logic [7:0] c);
			return c >= 48 && c <= 57;
		endfunction
		function bit opc(logic [7:0] c);
			return !ws(c) && !letter(c) && !digit(c);
		endfunction
		function bit term(logic [7:0] c);
			return c == 40 || c == 41 || c == 91 || c == 93 || c == 123 || c == 125 ||
				c == 59 || c == 44 || c == CH_SQUOTE || c == CH_DQUOTE;
		endfunction

		// Decide whether the token ends after c with nx following; track quotes.
		function bit token_ends(logic [7:0] c, logic [7:0] nx);
			if (c == CH_DQUOTE && !in_chr && !in_str) begin
				in_str = 1;
				return 0;
			end
			if (nx == CH_DQUOTE && in_str) return 0;
			if (c == CH_DQUOTE && in_str) begin
				in_str = 0;
				return 1;
			end
			if (in_str) return 0;
			if (c == CH_SQUOTE && !in_chr) begin
				in_chr = 1;
				return 0;
			end
			if (nx == CH_SQUOTE && in_chr) return 0;
			if (c == CH_SQUOTE && in_chr) begin
				in_chr = 0;
				return 1;
			end
			if (in_chr) return 0;
			if (ws(nx) || term(c) || term(nx)) return 1;
			if (c == CH_HASH) return 0;
			if ((letter(c) && letter(nx)) || (digit(c) && digit(nx)) ||
				(letter(c) && digit(nx)) || (opc(c) && opc(nx))) return 0;
			return 1;
		endfunction

		function void append(logic [7:0] c);
			if (tlen == 0) begin
				tok_line = line_no;
				tok_col = col_no - 16'd1;
				acc = 0;
				cut = 0;
			end
			if (tlen < 32) begin
				buf_b[tlen] = c;
				tlen++;
			end else cut = 1;
			if (digit(c)) acc = acc * 32'd10 + 32'(c - CH_ZERO);
		endfunction

		function logic [5:0] kind_of();
			bit hit;
			if (buf_b[0] == CH_DQUOTE) return KIND_STRING;
			if (buf_b[0] == CH_SQUOTE) return KIND_CHAR;
			if (!cut) begin
				if (tlen == 1)
					for (int i = 0; i < ops.len(); i++)
						if (ops[i] == buf_b[0]) return KIND_OP0 + 6'(i);
				for (int w = 0; w < 27; w++) begin
					hit = words[w].len() == tlen;
					for (int i = 0; hit && i < tlen; i++)
						if (words[w][i] != buf_b[i]) hit = 0;
					if (hit) return KIND_WORD0 + 6'(w);
				end
			end
			if (letter(buf_b[0])) return KIND_IDENT;
			if (digit(buf_b[0])) return KIND_NUMBER;
			return KIND_UNKNOWN;
		endfunction

		function void push(logic [5:0] k, logic [31:0] v, logic [7:0] b, logic tv,
				logic [15:0] ln, logic [15:0] cl, logic ov, logic lst);
			token_xfer_t t;
			t.kind = k; t.value = v; t.tbyte = b; t.tvalid = tv;
			t.line = ln; t.col = cl; t.ovf = ov; t.last = lst;
			pending.push_back(t);
		endfunction

		function void flush_token();
			logic [5:0]  k;
			logic [31:0] v;
			int lo, hi;
			k = kind_of();
			v = (k == KIND_NUMBER) ? acc : 32'd0;
			lo = 0;
			hi = 0;
			if (k == KIND_IDENT) hi = tlen;
			else if (k == KIND_CHAR || k == KIND_STRING) begin
				lo = 1;
				hi = tlen;
				if (!cut && tlen >= 2 && buf_b[tlen-1] == buf_b[0]) hi--;
			end
			if (hi > lo)
				for (int i = lo; i < hi; i++)
					push(k, v, buf_b[i], 1, tok_line, tok_col, cut, i + 1 == hi);
			else push(k, v, 0, 0, tok_line, tok_col, cut, 1);
			tlen = 0;
			cut = 0;
		endfunction

		// Note an accepted input transfer and queue the results it causes.
		function void note_input(logic [7:0] b, logic eoi);
			logic [7:0] c;
			if (done) return;
			if (eoi) begin
				if (la_ok && !in_cmt && (tlen > 0 || !ws(la_char))) append(la_char);
				la_ok = 0;
				if (tlen > 0) flush_token();
				push(KIND_END, 0, 0, 0, line_no, col_no, 0, 1);
				in_str = 0; in_chr = 0; in_cmt = 0; done = 1;
				return;
			end
			if (la_ok) begin
				c = la_char;
				if (in_cmt) begin
					if (c == CH_LF) in_cmt = 0;
				end else if (tlen == 0 && ws(c)) begin
				end else if (tlen == 0 && c == CH_SLASH && b == CH_SLASH) begin
					in_cmt = 1;
				end else begin
					append(c);
					if (token_ends(c, b)) flush_token();
				end
			end
			la_char = b;
			la_ok = 1;
			if (b == CH_LF) begin
				line_no++;
				col_no = 1;
			end else col_no++;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
			errors++;
		endtask

		task check_result(token_xfer_t got);
			token_xfer_t w;
			if (pending.size() == 0) begin
				report("unexpected transfer kind", got.kind, 0);
				return;
			end
			w = pending.pop_front();
			if (got.kind !== w.kind) report("token_kind", got.kind, w.kind);
			if (got.value !== w.value) report("int_value", got.value, w.value);
			if (got.tbyte !== w.tbyte) report("text_byte", got.tbyte, w.tbyte);
			if (got.tvalid !== w.tvalid) report("text_valid", got.tvalid, w.tvalid);
			if (got.line !== w.line) report("start_line", got.line, w.line);
			if (got.col !== w.col) report("start_column", got.col, w.col);
			if (got.ovf !== w.ovf) report("text_overflow", got.ovf, w.ovf);
			if (got.last !== w.last) report("last_of_token", got.last, w.last);
		endtask
	endclass

	logic        clk, arst_n;
	logic        in_valid, in_stall, end_of_input, out_valid, out_stall;
	logic [7:0]  in_byte, text_byte;
	logic [5:0]  token_kind;
	logic [31:0] int_value;
	logic [15:0] start_line, start_column;
	logic        text_valid, text_overflow, last_of_token;

	token_board  board;
	int          send_idle_pct, stall_pct;
	bit          hold_req;
	logic [7:0]  source_q[$];

	c_subset_token_scanner u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Give up on a hung run.
	initial begin
		#3ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: take results, stall at random, and hold off long on request.
	initial begin
		token_xfer_t t;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				t.kind = token_kind; t.value = int_value; t.tbyte = text_byte;
				t.tvalid = text_valid; t.line = start_line; t.col = start_column;
				t.ovf = text_overflow; t.last = last_of_token;
				board.check_result(t);
			end
			if (hold_req) begin
				// hold off while the sender keeps offering
				out_stall <= 1;
				repeat (400) @(posedge clk);
				hold_req = 0;
				out_stall <= 0;
			end else out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one byte, with an optional random gap first; note it on transfer.
	task send(logic [7:0] b, logic eoi);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_byte <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (in_stall);
		board.note_input(b, eoi);
	endtask

	task add_text(string s);
		for (int i = 0; i < s.len(); i++) source_q.push_back(s[i]);
	endtask

	task add_random_chars(int n, int lo, int hi);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(hi, lo));
			// keep quotes out of literal and comment bodies
			if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_LF) c = "q";
			source_q.push_back(c);
		end
	endtask

	// Append one random C-like fragment, mostly well formed.
	task add_fragment();
		string idc;
		int n;
		idc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		case ($urandom_range(10))
			0: add_text(board.words[$urandom_range(9, 26)]);
			1: begin
				n = ($urandom_range(9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 8);
				source_q.push_back(idc[$urandom_range(52)]);
				for (int i = 1; i < n; i++) source_q.push_back(idc[$urandom_range(62)]);
			end
			2: begin
				n = $urandom_range(1, 14);
				for (int i = 0; i < n; i++) source_q.push_back(idc[$urandom_range(62, 53)]);
			end
			3: if ($urandom_range(1)) add_text(board.words[$urandom_range(8)]);
				else source_q.push_back(board.ops[$urandom_range(21)]);
			4: begin
				source_q.push_back(CH_DQUOTE);
				add_random_chars(($urandom_range(7) == 0) ? $urandom_range(32, 38) :
					$urandom_range(0, 6), 32, 126);
				source_q.push_back(CH_DQUOTE);
			end
			5: begin
				source_q.push_back(CH_SQUOTE);
				add_random_chars($urandom_range(1), 32, 126);
				source_q.push_back(CH_SQUOTE);
			end
			6: begin
				add_text("//");
				add_random_chars($urandom_range(0, 8), 0, 255);
				source_q.push_back(CH_LF);
			end
			7: add_text("#include");
			8: source_q.push_back(8'($urandom_range(255)));
			default: add_text("x = y->z;");
		endcase
		if ($urandom_range(9) < 6) begin
			case ($urandom_range(3))
				0: source_q.push_back(8'd32);
				1: source_q.push_back(8'd9);
				2: source_q.push_back(8'd13);
				default: source_q.push_back(CH_LF);
			endcase
		end
	endtask

	task drain_source();
		while (source_q.size() > 0) send(source_q.pop_front(), 0);
	endtask

	initial begin
		board = new();
		arst_n = 0;
		in_valid = 0;
		in_byte = 0;
		end_of_input = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: keywords, numbers that wrap, all operators, literals, comments,
		// odd bytes, overlong tokens and mismatched quotes.
		add_text("int f(){while(x<=4294967297)return a->b;}// c\n");
		add_text("+-*/%=<>&|^~![](){};,: == >= << >> && || != ");
		add_text("'a' '' \"\" \"s'q\" 'b\" #include ");
		source_q.push_back(8'd0);
		source_q.push_back(8'd255);
		add_text(" abcdefghijabcdefghijabcdefghij0123456789 ");
		add_text("\"abcdefghijabcdefghijabcdefghijklmnop\"\n");
		drain_source();

		// Random phases with different idling on each side.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 72) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 72) : 0;
			if (ph == 0) hold_req = 1;
			while (source_q.size() < 28) add_fragment();
			drain_source();
		end
		send_idle_pct = 0;
		stall_pct = 20;

		// Leave a string open so the end flushes it, then mark end of source.
		add_text("\"open");
		drain_source();
		send(0, 1);
		send(8'hA5, 0);
		in_valid <= 0;

		while (board.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/csts_pkg.sv
src/csts_ctl.sv
src/csts_dp.sv
src/c_subset_token_scanner.sv
verif/c_subset_token_scanner_tb.sv
